// ===== sv/rc4kc_pkg.sv =====
`timescale 1ns / 1ps

package rc4kc_pkg;

   localparam int BYTE_W = 8;
   localparam int PERM_DEPTH = 256;

   localparam logic REQ_KEY  = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_FILL,
      OP_KEY,
      OP_DATA,
      OP_KS_A,
      OP_KS_B,
      OP_KS_C,
      OP_KS_D,
      OP_GEN_A,
      OP_GEN_B,
      OP_GEN_C,
      OP_GEN_D
   } op_type;

   typedef struct packed {
      op_type op;
      logic   push;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic out_free;
   } status_type;

endpackage

// ===== sv/rc4kc_if.sv =====
`timescale 1ns / 1ps

interface rc4kc_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] in_byte;
   logic       last;

   modport source (output valid, output req_type, output in_byte, output last, input ready);
   modport sink (input valid, input req_type, input in_byte, input last, output ready);
endinterface

interface rc4kc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [7:0] keystream_byte;
   logic       keyed;

   modport source (output valid, output out_byte, output keystream_byte, output keyed,
                   input ready);
   modport sink (input valid, input out_byte, input keystream_byte, input keyed,
                 output ready);
endinterface

// ===== sv/rc4_keystream_cipher_top.sv =====
`timescale 1ns / 1ps

// RC4 stream cipher with byte-serial key loading. After reset the block writes the identity
// permutation into its permutation RAM, with request ready held low. A key byte that is not
// the last one is taken while idle. The last key byte starts the key schedule, which first
// restores the identity and then performs the 256 swap steps, each through KS_A to KS_D. A
// data request passes through GEN_A to GEN_D, and its result enters the output register from
// GEN_D, which waits while an earlier result is untaken. No data request is accepted before
// the one ahead is through, because the reads of S[i], S[j] and S[S[i]+S[j]] depend on one
// another and share the single read port of the permutation RAM; a new request is accepted
// while an earlier result still waits to be taken.
// Data sent before any key uses the identity permutation and reports keyed as zero.

module rc4_keystream_cipher_top #(
   parameter int MAX_KEY_LEN = 256
) (
   input logic         clock,
   input logic         reset,
   rc4kc_req_if.sink   req_ch,
   rc4kc_rsp_if.source rsp_ch
);

   import rc4kc_pkg::*;

   cmd_type    cmd;
   status_type status;

   rc4kc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_last  (req_ch.last),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   rc4kc_datapath #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .in_byte        (req_ch.in_byte),
      .last           (req_ch.last),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .out_byte       (rsp_ch.out_byte),
      .keystream_byte (rsp_ch.keystream_byte),
      .keyed          (rsp_ch.keyed)
   );

endmodule

// ===== sv/rc4kc_ram.sv =====
`timescale 1ns / 1ps

module rc4kc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/rc4kc_ctrl.sv =====
`timescale 1ns / 1ps

module rc4kc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_type,
   input  logic                   req_last,
   output logic                   req_ready,
   output rc4kc_pkg::cmd_type     cmd,
   input  rc4kc_pkg::status_type  status
);

   import rc4kc_pkg::*;

   typedef enum logic [9:0] {
      ST_FILL  = 10'b0000000001,
      ST_IDLE  = 10'b0000000010,
      ST_KS_A  = 10'b0000000100,
      ST_KS_B  = 10'b0000001000,
      ST_KS_C  = 10'b0000010000,
      ST_KS_D  = 10'b0000100000,
      ST_GEN_A = 10'b0001000000,
      ST_GEN_B = 10'b0010000000,
      ST_GEN_C = 10'b0100000000,
      ST_GEN_D = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      sched_ff, sched_in;

   always_comb begin
      state_in  = state_ff;
      sched_in  = sched_ff;
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.push  = 1'b0;
      case (state_ff)
         ST_FILL: begin
            cmd.op = OP_FILL;
            if (status.sweep_last) begin
               state_in = sched_ff ? ST_KS_A : ST_IDLE;
               sched_in = 1'b0;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type == REQ_KEY) begin
                  cmd.op = OP_KEY;
                  if (req_last) begin
                     state_in = ST_FILL;
                     sched_in = 1'b1;
                  end
               end else begin
                  cmd.op   = OP_DATA;
                  state_in = ST_GEN_A;
               end
            end
         end
         ST_KS_A: begin
            cmd.op   = OP_KS_A;
            state_in = ST_KS_B;
         end
         ST_KS_B: begin
            cmd.op   = OP_KS_B;
            state_in = ST_KS_C;
         end
         ST_KS_C: begin
            cmd.op   = OP_KS_C;
            state_in = ST_KS_D;
         end
         ST_KS_D: begin
            cmd.op   = OP_KS_D;
            state_in = status.sweep_last ? ST_IDLE : ST_KS_A;
         end
         ST_GEN_A: begin
            cmd.op   = OP_GEN_A;
            state_in = ST_GEN_B;
         end
         ST_GEN_B: begin
            cmd.op   = OP_GEN_B;
            state_in = ST_GEN_C;
         end
         ST_GEN_C: begin
            cmd.op   = OP_GEN_C;
            state_in = ST_GEN_D;
         end
         ST_GEN_D: begin
            cmd.op = OP_GEN_D;
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            sched_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         sched_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sched_ff <= sched_in;
      end
   end

endmodule

// ===== sv/rc4kc_datapath.sv =====
`timescale 1ns / 1ps

module rc4kc_datapath #(
   parameter int MAX_KEY_LEN = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rc4kc_pkg::cmd_type     cmd,
   output rc4kc_pkg::status_type  status,
   input  logic [7:0]             in_byte,
   input  logic                   last,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [7:0]             out_byte,
   output logic [7:0]             keystream_byte,
   output logic                   keyed
);

   import rc4kc_pkg::*;

   localparam int KA_W = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
   localparam int KC_W = $clog2(MAX_KEY_LEN + 1);
   localparam logic [KC_W-1:0] KEY_MAX = KC_W'(MAX_KEY_LEN);

   logic [7:0]      k_ff, k_in;
   logic [KA_W-1:0] kidx_ff, kidx_in;
   logic [KC_W-1:0] klen_ff, klen_in;
   logic [KC_W-1:0] key_count_ff, key_count_in;
   logic [7:0]      i_ff, i_in;
   logic [7:0]      j_ff, j_in;
   logic [7:0]      si_ff, si_in;
   logic [7:0]      sj_ff, sj_in;
   logic [7:0]      data_ff, data_in;
   logic            keyed_ff, keyed_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_out_ff, rsp_out_in;
   logic [7:0]      rsp_ks_ff, rsp_ks_in;
   logic            rsp_keyed_ff, rsp_keyed_in;

   logic            p_we;
   logic [7:0]      p_waddr, p_wdata, p_raddr, p_rdata;
   logic            k_we;
   logic [KA_W-1:0] k_waddr, k_raddr;
   logic [7:0]      k_rdata;

   logic [7:0]      j_next;
   logic [7:0]      t_addr;
   logic [7:0]      ks;
   logic [KC_W-1:0] kidx_inc;
   logic            out_free;

   rc4kc_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .raddr (p_raddr),
      .rdata (p_rdata)
   );

   rc4kc_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_KEY_LEN)) u_key_ram (
      .clock (clock),
      .we    (k_we),
      .waddr (k_waddr),
      .wdata (in_byte),
      .raddr (k_raddr),
      .rdata (k_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign status.sweep_last = (k_ff == 8'hFF);
   assign status.out_free = out_free;
   assign kidx_inc = KC_W'(kidx_ff) + KC_W'(1);
   assign t_addr = si_ff + sj_ff;

   // The keystream read overlaps the swap writes, so the swapped entries are forwarded.
   always_comb begin
      if (t_addr == j_ff) begin
         ks = si_ff;
      end else if (t_addr == i_ff) begin
         ks = sj_ff;
      end else begin
         ks = p_rdata;
      end
   end

   always_comb begin
      k_in         = k_ff;
      kidx_in      = kidx_ff;
      klen_in      = klen_ff;
      key_count_in = key_count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      data_in      = data_ff;
      keyed_in     = keyed_ff;
      rsp_out_in   = rsp_out_ff;
      rsp_ks_in    = rsp_ks_ff;
      rsp_keyed_in = rsp_keyed_ff;
      p_we         = 1'b0;
      p_waddr      = k_ff;
      p_wdata      = k_ff;
      p_raddr      = k_ff;
      k_we         = 1'b0;
      k_waddr      = key_count_ff[KA_W-1:0];
      k_raddr      = kidx_ff;
      j_next       = 8'(j_ff + p_rdata);
      case (cmd.op)
         OP_FILL: begin
            p_we    = 1'b1;
            k_in    = 8'(k_ff + 8'd1);
            j_in    = 8'd0;
            kidx_in = '0;
         end
         OP_KEY: begin
            if (key_count_ff < KEY_MAX) begin
               k_we         = 1'b1;
               key_count_in = KC_W'(key_count_ff + KC_W'(1));
            end
            if (last) begin
               klen_in      = (key_count_ff < KEY_MAX) ?
                              KC_W'(key_count_ff + KC_W'(1)) : key_count_ff;
               key_count_in = '0;
            end
         end
         OP_DATA: begin
            data_in = in_byte;
            i_in    = 8'(i_ff + 8'd1);
         end
         OP_KS_A: begin
            p_raddr = k_ff;
         end
         OP_KS_B: begin
            j_next  = 8'(j_ff + p_rdata + k_rdata);
            si_in   = p_rdata;
            j_in    = j_next;
            p_raddr = j_next;
         end
         OP_KS_C: begin
            sj_in   = p_rdata;
            p_we    = 1'b1;
            p_waddr = k_ff;
            p_wdata = p_rdata;
         end
         OP_KS_D: begin
            p_we    = 1'b1;
            p_waddr = j_ff;
            p_wdata = si_ff;
            k_in    = 8'(k_ff + 8'd1);
            kidx_in = (kidx_inc == klen_ff) ? '0 : kidx_inc[KA_W-1:0];
            if (k_ff == 8'hFF) begin
               i_in     = 8'd0;
               j_in     = 8'd0;
               keyed_in = 1'b1;
            end
         end
         OP_GEN_A: begin
            p_raddr = i_ff;
         end
         OP_GEN_B: begin
            si_in   = p_rdata;
            j_in    = j_next;
            p_raddr = j_next;
         end
         OP_GEN_C: begin
            sj_in   = p_rdata;
            p_we    = 1'b1;
            p_waddr = i_ff;
            p_wdata = p_rdata;
            p_raddr = 8'(si_ff + p_rdata);
         end
         OP_GEN_D: begin
            p_we    = 1'b1;
            p_waddr = j_ff;
            p_wdata = si_ff;
            p_raddr = t_addr;
            if (cmd.push) begin
               rsp_out_in   = data_ff ^ ks;
               rsp_ks_in    = ks;
               rsp_keyed_in = keyed_ff;
            end
         end
         default: begin
            p_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= 8'd0;
         key_count_ff <= '0;
         i_ff         <= 8'd0;
         j_ff         <= 8'd0;
         keyed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         key_count_ff <= key_count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         keyed_ff     <= keyed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kidx_ff      <= kidx_in;
      klen_ff      <= klen_in;
      si_ff        <= si_in;
      sj_ff        <= sj_in;
      data_ff      <= data_in;
      rsp_out_ff   <= rsp_out_in;
      rsp_ks_ff    <= rsp_ks_in;
      rsp_keyed_ff <= rsp_keyed_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign out_byte       = rsp_out_ff;
   assign keystream_byte = rsp_ks_ff;
   assign keyed          = rsp_keyed_ff;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import rc4kc_pkg::*;

   typedef struct {
      logic             kind;
      logic [BYTE_W-1:0] value;
      logic             mark;
      bit               hold;
   } cipher_req_type;

   typedef struct {
      logic [BYTE_W-1:0] out_byte;
      logic [BYTE_W-1:0] keystream_byte;
      logic              keyed;
   } cipher_rsp_type;

   logic clock;
   logic reset;

   rc4kc_req_if req_if ();
   rc4kc_rsp_if rsp_if ();

   rc4_keystream_cipher_top u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   always #5 clock = ~clock;

   cipher_req_type pending_reqs[$];
   cipher_rsp_type expected_bytes[$];
   cipher_rsp_type want;

   logic [BYTE_W-1:0] perm[PERM_DEPTH];
   logic [BYTE_W-1:0] key_buf[PERM_DEPTH];
   int unsigned       key_len;
   logic [BYTE_W-1:0] gen_i;
   logic [BYTE_W-1:0] gen_j;
   logic              keyed_now;

   int n_accepted;
   int n_schedules;
   int n_results;
   int n_errors;

   function automatic int idle_phase();
      return (n_accepted / 200) % 4;
   endfunction

   task automatic swap_perm(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] t;
      t = perm[a];
      perm[a] = perm[b];
      perm[b] = t;
   endtask

   task automatic schedule_key(input int unsigned len);
      logic [BYTE_W-1:0] j;
      j = '0;
      for (int k = 0; k < PERM_DEPTH; k++) perm[k] = k[BYTE_W-1:0];
      for (int k = 0; k < PERM_DEPTH; k++) begin
         j = j + perm[k] + key_buf[k % len];
         swap_perm(k[BYTE_W-1:0], j);
      end
      gen_i = '0;
      gen_j = '0;
      keyed_now = 1'b1;
   endtask

   task automatic advance_cipher(input logic kind, input logic [BYTE_W-1:0] value,
                                 input logic mark);
      logic [BYTE_W-1:0] ks_index;
      cipher_rsp_type    r;
      if (kind == REQ_KEY) begin
         if (key_len < PERM_DEPTH) begin
            key_buf[key_len] = value;
            key_len++;
         end
         if (mark) begin
            schedule_key(key_len);
            key_len = 0;
            n_schedules++;
         end
      end else begin
         gen_i = gen_i + 8'd1;
         gen_j = gen_j + perm[gen_i];
         swap_perm(gen_i, gen_j);
         ks_index = perm[gen_i] + perm[gen_j];
         r.keystream_byte = perm[ks_index];
         r.out_byte = value ^ r.keystream_byte;
         r.keyed = keyed_now;
         expected_bytes.push_back(r);
      end
   endtask

   task automatic add_req(input logic kind, input logic [BYTE_W-1:0] value, input logic mark,
                          input bit hold = 1'b0);
      cipher_req_type q;
      q.kind = kind;
      q.value = value;
      q.mark = mark;
      q.hold = hold;
      pending_reqs.push_back(q);
   endtask

   // Data requests may be slipped in between the bytes of a key that is still loading.
   task automatic add_key(input int len, input int mix_pct);
      for (int k = 0; k < len; k++) begin
         if (k < len - 1 && $urandom_range(0, 99) < mix_pct)
            add_req(REQ_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         add_req(REQ_KEY, 8'($urandom_range(0, 255)), k == len - 1);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.req_type <= REQ_KEY;
         req_if.in_byte <= '0;
         req_if.last <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            advance_cipher(req_if.req_type, req_if.in_byte, req_if.last);
            n_accepted++;
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (pending_reqs.size() != 0 &&
                !(pending_reqs[0].hold && expected_bytes.size() != 0) &&
                !(idle_phase() == 1 && $urandom_range(0, 99) < 61) &&
                !(idle_phase() == 3 && $urandom_range(0, 99) < 8)) begin
               req_if.valid <= 1'b1;
               req_if.req_type <= pending_reqs[0].kind;
               req_if.in_byte <= pending_reqs[0].value;
               req_if.last <= pending_reqs[0].mark;
               void'(pending_reqs.pop_front());
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            n_results++;
            if (expected_bytes.size() == 0) begin
               $error("unexpected result: out_byte %0h keystream_byte %0h keyed %0b",
                      rsp_if.out_byte, rsp_if.keystream_byte, rsp_if.keyed);
               n_errors++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_if.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_if.out_byte);
                  n_errors++;
               end
               if (rsp_if.keystream_byte !== want.keystream_byte) begin
                  $error("keystream_byte: expected %0h, got %0h", want.keystream_byte,
                         rsp_if.keystream_byte);
                  n_errors++;
               end
               if (rsp_if.keyed !== want.keyed) begin
                  $error("keyed: expected %0b, got %0b", want.keyed, rsp_if.keyed);
                  n_errors++;
               end
            end
         end
         rsp_if.ready <= !((idle_phase() == 2 && $urandom_range(0, 99) < 61) ||
                           (idle_phase() == 3 && $urandom_range(0, 99) < 8));
      end
   end

   initial begin
      int round;
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.req_type = REQ_KEY;
      req_if.in_byte = '0;
      req_if.last = 1'b0;
      rsp_if.ready = 1'b0;
      for (int k = 0; k < PERM_DEPTH; k++) begin
         perm[k] = k[BYTE_W-1:0];
         key_buf[k] = '0;
      end
      key_len = 0;
      gen_i = '0;
      gen_j = '0;
      keyed_now = 1'b0;
      n_accepted = 0;
      n_schedules = 0;
      n_results = 0;
      n_errors = 0;

      // Data before any key, including a stray last mark on a data request.
      add_req(REQ_DATA, 8'h00, 1'b0);
      add_req(REQ_DATA, 8'hFF, 1'b0);
      add_req(REQ_DATA, 8'hA5, 1'b1);
      add_req(REQ_KEY, 8'h00, 1'b1);
      add_req(REQ_DATA, 8'h00, 1'b0);
      add_req(REQ_DATA, 8'hFF, 1'b0);
      add_req(REQ_KEY, 8'hFF, 1'b0);
      add_req(REQ_DATA, 8'h5A, 1'b0);
      add_req(REQ_KEY, 8'h80, 1'b0);
      add_req(REQ_KEY, 8'h01, 1'b1);
      add_req(REQ_DATA, 8'h3C, 1'b1);
      add_req(REQ_DATA, 8'hC3, 1'b0);
      add_req(REQ_KEY, 8'hFF, 1'b1, 1'b1);
      add_req(REQ_DATA, 8'h7F, 1'b0);
      add_req(REQ_DATA, 8'h80, 1'b0);

      // A key of the full length, then one whose tail is dropped while its last mark still
      // starts the schedule.
      add_key(PERM_DEPTH, 0);
      for (int k = 0; k < 4; k++) add_req(REQ_DATA, 8'($urandom_range(0, 255)), 1'b0);
      add_key(PERM_DEPTH + 4, 0);
      for (int k = 0; k < 4; k++) add_req(REQ_DATA, 8'($urandom_range(0, 255)), 1'b0);

      round = 0;
      while (pending_reqs.size() < 950) begin
         round++;
         if ($urandom_range(0, 99) < 20) begin
            add_key($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 16),
                    $urandom_range(0, 3) == 0 ? 30 : 0);
         end else begin
            add_req(REQ_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    round % 20 == 0);
            repeat ($urandom_range(0, 23))
               add_req(REQ_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_if.valid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("testbench: %0d requests, %0d key schedules, %0d results checked",
               n_accepted, n_schedules, n_results);
      if (n_errors == 0 && expected_bytes.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
